@@ src/q41d_pkg.sv @@
package q41d_pkg;
    localparam int BLOCK_VALUES_DEF = 32;
    localparam int NIBBLE_W = 4;
    localparam int BYTES_PER_BLOCK = 16;
    localparam logic [3:0] NIB_MASK = 4'hF;
    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef struct packed {
        logic        zero;
        logic        inf;
        logic        nan;
        logic        sign;
        logic signed [6:0] exp;
        logic [10:0] man;
    } t_half_unp;

    // value = (-1)^sign * man * 2^(exp-10), man with explicit leading bit
    function automatic t_half_unp unpack_half(input logic [15:0] h);
        t_half_unp r;
        r.sign = h[15];
        r.zero = (h[14:0] == 15'd0);
        r.inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
        r.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
        if (h[14:10] == 5'd0) begin
            r.man = {1'b0, h[9:0]};
            r.exp = -7'sd14;
        end else begin
            r.man = {1'b1, h[9:0]};
            r.exp = 7'(signed'({2'b00, h[14:10]})) - 7'sd15;
        end
        return r;
    endfunction
endpackage

@@ src/q41d_if.sv @@
interface q41d_if #(parameter int W = 1) (input logic i_clk);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ src/q41d_fma.sv @@
// scale*nib + min, exact product, one rounding to single, 4 register stages
module q41d_fma
    import q41d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_half_unp   i_scale,
    input  t_half_unp   i_min,
    input  logic [3:0]  i_nib,
    input  logic [5:0]  i_tag,
    output logic        o_valid,
    output logic [31:0] o_value,
    output logic [5:0]  o_tag
);
    // all finite values are integers times 2^-24; product < 2^44, min < 2^40
    localparam int FW = 44;

    // stage 1: product and special classification
    logic [3:0]        r1_v;
    logic [5:0]        r1_tag [4];
    logic [14:0]       r1_pm;
    logic signed [6:0] r1_pe;
    logic              r1_ps, r1_ms;
    logic [10:0]       r1_mm;
    logic signed [6:0] r1_me;
    logic              r1_spec;
    logic [31:0]       r1_sval;

    logic        n_spec;
    logic [31:0] n_sval;
    logic        p_inf, p_nan, p_sign;
    always_comb begin
        p_sign = i_scale.sign;
        p_nan = i_scale.nan || (i_scale.inf && i_nib == 4'd0);
        p_inf = i_scale.inf && i_nib != 4'd0;
        n_spec = 1'b1;
        n_sval = CANON_NAN;
        if (p_nan || i_min.nan || (p_inf && i_min.inf && p_sign != i_min.sign)) begin
            n_sval = CANON_NAN;
        end else if (p_inf) begin
            n_sval = {p_sign, 31'h7F80_0000};
        end else if (i_min.inf) begin
            n_sval = {i_min.sign, 31'h7F80_0000};
        end else begin
            n_spec = 1'b0;
        end
    end

    // stage 2: align to fixed point, signed sum
    logic signed [FW+1:0] r2_sum;
    logic                 r2_spec;
    logic [31:0]          r2_sval;
    logic                 r2_zs;
    // stage 3: magnitude and leading one
    logic [FW:0]          r3_mag;
    logic [5:0]           r3_lz;
    logic                 r3_sign, r3_spec;
    logic [31:0]          r3_sval;
    // stage 4: output
    logic [31:0]          r4_val;

    logic [FW-1:0] a_p, a_m;
    logic signed [FW+1:0] n_sum;
    logic [FW:0] n_mag;
    logic [5:0] n_lz;
    always_comb begin
        a_p = FW'(r1_pm) << 6'(r1_pe + 7'sd14);
        a_m = FW'(r1_mm) << 6'(r1_me + 7'sd14);
        n_sum = (r1_ps ? -$signed({2'b00, a_p}) : $signed({2'b00, a_p}))
              + (r1_ms ? -$signed({2'b00, a_m}) : $signed({2'b00, a_m}));
        n_mag = r2_sum[FW+1] ? (FW+1)'(-r2_sum) : (FW+1)'(r2_sum);
        n_lz = 6'd0;
        for (int b = 0; b <= FW; b++) begin
            if (n_mag[b]) n_lz = 6'(b);
        end
    end

    // round: value = mag * 2^-24, msb at bit lz
    logic [FW+24:0] sh;
    logic [23:0] mant;
    logic g, st;
    logic [7:0] ex;
    logic [24:0] rm;
    logic [31:0] n_val;
    always_comb begin
        sh = '0;
        mant = '0;
        g = 1'b0;
        st = 1'b0;
        ex = '0;
        rm = '0;
        if (r3_mag == '0) begin
            n_val = {r3_sign, 31'd0};
        end else begin
            // shift so msb lands at bit FW+24 for normals
            sh = {r3_mag, 24'd0} << 6'(FW - r3_lz);
            // unbiased exp = lz-24; biased = lz+103; >= 1 always here
            ex = 8'(r3_lz + 6'd0) + 8'd103;
            mant = sh[FW+24 -: 24];
            g = sh[FW];
            st = |sh[FW-1:0];
            rm = {1'b0, mant} + 25'(g && (st || mant[0]));
            if (rm[24]) begin
                rm = rm >> 1;
                ex = ex + 8'd1;
            end
            n_val = {r3_sign, ex, rm[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= '0;
        end else if (i_en) begin
            r1_v <= {r1_v[2:0], i_valid};
        end
        if (i_en) begin
            r1_tag[0] <= i_tag;
            for (int s = 1; s < 4; s++) r1_tag[s] <= r1_tag[s-1];
            r1_pm <= i_scale.man * i_nib;
            r1_pe <= i_scale.exp;
            r1_ps <= i_scale.sign;
            r1_mm <= i_min.man;
            r1_me <= i_min.exp;
            r1_ms <= i_min.sign;
            r1_spec <= n_spec;
            r1_sval <= n_sval;
            r2_sum <= n_sum;
            r2_spec <= r1_spec;
            r2_sval <= r1_sval;
            // exact zero sum is -0 only if both terms are negative zeros
            r2_zs <= r1_ps && r1_ms;
            r3_mag <= n_mag;
            r3_lz <= n_lz;
            r3_sign <= (r2_sum == '0) ? r2_zs : r2_sum[FW+1];
            r3_spec <= r2_spec;
            r3_sval <= r2_sval;
            r4_val <= r3_spec ? r3_sval : n_val;
        end
    end

    assign o_valid = r1_v[3];
    assign o_value = r4_val;
    assign o_tag = r1_tag[3];
endmodule

@@ src/q4_1_block_dequantizer.sv @@
// Q4_1 block dequantizer.
// Input channel carries one block: half scale, half minimum, 16 packed
// bytes. The output channel carries one value per transfer: the single
// value scale*nibble+min, its position 0..31 and a last flag on position 31.
// Positions 0..15 use low nibbles of bytes 0..15, 16..31 the high nibbles.
// A block is held in a register while a counter walks its 32 nibbles
// into a four-stage arithmetic pipeline followed by an output register.
// Throughput: one value per cycle unless the receiver stalls; the next
// block is taken in the cycle the current block's last nibble is issued.
// Reset clears the counter and all valid bits; no block is pending.
// When the receiver stalls the whole pipeline holds, nothing is lost or
// repeated, and input is refused once the held block is in use.
module q4_1_block_dequantizer
    import q41d_pkg::*;
#(
    parameter int BLOCK_VALUES = BLOCK_VALUES_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    q41d_if.sink   i_blk,
    q41d_if.source o_val
);
    localparam int PW = $clog2(BLOCK_VALUES);

    logic              r_full;
    logic [PW-1:0]     r_pos;
    logic [15:0]       r_scale, r_min;
    logic [127:0]      r_bytes;
    logic              r_ov;
    logic [31:0]       r_oval;
    logic [PW-1:0]     r_opos;
    logic              r_olast;

    logic en, issue, take, f_v;
    logic [31:0] f_val;
    logic [5:0] f_tag;
    logic [3:0] nib;
    logic [7:0] byt;

    assign en = !r_ov || o_val.ready;
    assign issue = en && r_full;
    assign i_blk.ready = !r_full || (issue && r_pos == PW'(BLOCK_VALUES - 1));
    assign take = i_blk.valid && i_blk.ready;
    assign byt = r_bytes[8*r_pos[3:0] +: 8];
    assign nib = r_pos[PW-1] ? byt[7:4] : (byt[3:0] & NIB_MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_pos <= '0;
            r_ov <= 1'b0;
        end else begin
            if (issue) r_pos <= r_pos + 1'b1;
            if (take) r_full <= 1'b1;
            else if (issue && r_pos == PW'(BLOCK_VALUES - 1)) r_full <= 1'b0;
            if (en) r_ov <= f_v;
        end
        if (take) begin
            r_scale <= i_blk.data[15:0];
            r_min <= i_blk.data[31:16];
            r_bytes <= i_blk.data[159:32];
        end
        if (en) begin
            r_oval <= f_val;
            r_opos <= PW'(f_tag[4:0]);
            r_olast <= f_tag[5];
        end
    end

    q41d_fma u_fma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (issue),
        .i_scale (unpack_half(r_scale)),
        .i_min   (unpack_half(r_min)),
        .i_nib   (nib),
        .i_tag   ({r_pos == PW'(BLOCK_VALUES - 1), 5'(r_pos)}),
        .o_valid (f_v),
        .o_value (f_val),
        .o_tag   (f_tag)
    );

    assign o_val.valid = r_ov;
    assign o_val.data = {r_olast, 5'(r_opos), r_oval};

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_olast == (r_opos == PW'(BLOCK_VALUES - 1))))
        else $error("last flag mismatch");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && r_pos != PW'(BLOCK_VALUES - 1)) |-> !i_blk.ready)
        else $error("block overwritten");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_val.ready) |=> (r_ov && $stable(r_oval) && $stable(r_opos)))
        else $error("output lost on stall");
endmodule

@@ verif/tb_q4_1_block_dequantizer.sv @@
module tb_q4_1_block_dequantizer;
    import q41d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLK_W = 160;
    localparam int VAL_W = 38;
    localparam int N_RANDOM = 470;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [15:0] scale;
        logic [15:0] minh;
        logic [63:0] lo;
        logic [63:0] hi;
        bit          fixed;
        logic [31:0] fixed_val;
    } t_vector;

    typedef struct {
        logic [31:0] value;
        logic [4:0]  pos;
        logic        last;
    } t_weight;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    q41d_if #(.W(BLK_W)) blk_if (i_clk);
    q41d_if #(.W(VAL_W)) val_if (i_clk);

    q4_1_block_dequantizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_blk   (blk_if),
        .o_val   (val_if)
    );

    always #10 i_clk = ~i_clk;

    t_weight  weights_q[$];
    t_vector  directed[$];
    int       errors = 0;
    int       idle_cnt = 0;
    bit       idle_on = 1'b1;
    bit       hold_req = 1'b0;
    bit       fixed_on = 1'b0;
    logic [31:0] fixed_val = '0;

    // half bit pattern to the exact double bit pattern
    function automatic logic [63:0] half_to_dbl(input logic [15:0] h);
        logic [63:0] d;
        logic [9:0]  m;
        int          ex;
        d = {h[15], 63'd0};
        m = h[9:0];
        if (h[14:10] == 5'h1F) begin
            d[62:52] = 11'h7FF;
            d[51:42] = m;
        end else if (h[14:10] == 5'd0) begin
            if (m != 10'd0) begin
                ex = -14;
                while (m[9] == 1'b0) begin
                    m = m << 1;
                    ex--;
                end
                m = m << 1;
                ex--;
                d[62:52] = 11'(ex + 1023);
                d[51:42] = m;
            end
        end else begin
            d[62:52] = 11'(int'(h[14:10]) - 15 + 1023);
            d[51:42] = m;
        end
        return d;
    endfunction

    // round a double to single, nearest even, subnormals kept
    function automatic logic [31:0] dbl_to_single(input logic [63:0] d);
        logic [63:0] sig, mant, rem, halfv;
        logic [31:0] res;
        int          ex, sh;
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hFF, 23'd0};
        if (d[62:0] == 63'd0)
            return {d[63], 31'd0};
        sig = {11'd0, 1'b1, d[51:0]};
        ex = int'(d[62:52]) - 1023;
        if (ex > 127)
            return {d[63], 8'hFF, 23'd0};
        sh = 29 + ((ex < -126) ? (-126 - ex) : 0);
        if (sh > 60)
            sh = 60;
        mant = sig >> sh;
        rem = sig & ((64'd1 << sh) - 64'd1);
        halfv = 64'd1 << (sh - 1);
        if (rem > halfv || (rem == halfv && mant[0]))
            mant = mant + 64'd1;
        res = (ex >= -126) ? ((32'(ex + 126) << 23) + 32'(mant)) : 32'(mant);
        return {d[63], res[30:0]};
    endfunction

    function automatic logic [31:0] dequant(input logic [15:0] scale, input logic [15:0] minh,
                                            input logic [3:0] nib);
        real s, m, r;
        s = $bitstoreal(half_to_dbl(scale));
        m = $bitstoreal(half_to_dbl(minh));
        r = s * real'(nib) + m;
        return dbl_to_single($realtobits(r));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // predict the 32 weights at each block transfer
    always @(posedge i_clk) begin
        logic [159:0] d;
        logic [7:0]   b;
        logic [3:0]   nib;
        t_weight      w;
        if (i_rst_n && blk_if.valid && blk_if.ready) begin
            d = blk_if.data;
            for (int k = 0; k < 32; k++) begin
                b = (k % 16 < 8) ? d[32 + 8*(k%8) +: 8] : d[96 + 8*(k%8) +: 8];
                nib = (k < 16) ? b[3:0] : b[7:4];
                w.value = fixed_on ? fixed_val : dequant(d[15:0], d[31:16], nib);
                w.pos = 5'(k);
                w.last = (k == 31);
                weights_q.push_back(w);
            end
        end
    end

    always @(posedge i_clk) begin
        t_weight w;
        if (i_rst_n && val_if.valid && val_if.ready) begin
            if (weights_q.size() == 0) begin
                report_mismatch("unexpected transfer", val_if.data[31:0], 32'd0);
            end else begin
                w = weights_q.pop_front();
                if (val_if.data[31:0] !== w.value)
                    report_mismatch("value", val_if.data[31:0], w.value);
                if (val_if.data[36:32] !== w.pos)
                    report_mismatch("position", 32'(val_if.data[36:32]), 32'(w.pos));
                if (val_if.data[37] !== w.last)
                    report_mismatch("last", 32'(val_if.data[37]), 32'(w.last));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((blk_if.valid && blk_if.ready) || (val_if.valid && val_if.ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        val_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                val_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                val_if.ready <= !(idle_on && $urandom_range(99) < 23);
            end
        end
    end

    task automatic send_block(input t_vector v);
        while (idle_on && $urandom_range(99) < 23) begin
            blk_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        fixed_on = v.fixed;
        fixed_val = v.fixed_val;
        blk_if.valid <= 1'b1;
        blk_if.data <= {v.hi, v.lo, v.minh, v.scale};
        @(posedge i_clk);
        while (!blk_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_half();
        case ($urandom_range(9))
            0: return {1'($urandom), 15'd0};
            1: return {1'($urandom), 5'h1F, 10'd0};
            2: return {1'($urandom), 5'h1F, 10'($urandom_range(1023, 1))};
            3: return {1'($urandom), 5'd0, 10'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_vector mk(input logic [15:0] s, input logic [15:0] m,
                                   input logic [63:0] lo, input logic [63:0] hi,
                                   input bit fx, input logic [31:0] fv);
        t_vector v;
        v.scale = s; v.minh = m; v.lo = lo; v.hi = hi; v.fixed = fx; v.fixed_val = fv;
        return v;
    endfunction

    initial begin
        t_vector v;
        int      waited;
        blk_if.valid = 1'b0;
        blk_if.data = '0;
        directed.push_back(mk(16'h0000, 16'h0000, '0, '0, 1, 32'h0000_0000));
        directed.push_back(mk(16'h8000, 16'h8000, '0, '0, 1, 32'h8000_0000));
        directed.push_back(mk(16'h7E00, 16'h3C00, '1, '0, 1, CANON_NAN));
        directed.push_back(mk(16'h3C00, 16'hFC01, '0, '1, 1, CANON_NAN));
        directed.push_back(mk(16'h7C00, 16'h0000, '0, '0, 1, CANON_NAN));
        directed.push_back(mk(16'h7C00, 16'hFC00, '1, '1, 1, CANON_NAN));
        directed.push_back(mk(16'h3C00, 16'h7C00, '1, '0, 1, 32'h7F80_0000));
        directed.push_back(mk(16'h3C00, 16'hFC00, 64'h0123_4567_89AB_CDEF, '1, 1,
                              32'hFF80_0000));
        directed.push_back(mk(16'h7C00, 16'h3C00, '1, '1, 1, 32'h7F80_0000));
        directed.push_back(mk(16'h3C00, 16'h0000, 64'h0123_4567_89AB_CDEF,
                              64'hFEDC_BA98_7654_3210, 0, 0));
        directed.push_back(mk(16'h7BFF, 16'h7BFF, '1, '1, 0, 0));
        directed.push_back(mk(16'hFBFF, 16'h7BFF, '1, 64'h0F0F_0F0F_0F0F_0F0F, 0, 0));
        directed.push_back(mk(16'h0001, 16'h8001, 64'h5A5A_5A5A_5A5A_5A5A, '1, 0, 0));
        directed.push_back(mk(16'h03FF, 16'h8400, 64'hA5A5_A5A5_A5A5_A5A5, '0, 0, 0));
        directed.push_back(mk(16'hB555, 16'h0000, 64'h0123_4567_89AB_CDEF, '0, 0, 0));
        directed.push_back(mk(16'h1234, 16'hC321, '1, 64'hF0F0_F0F0_F0F0_F0F0, 0, 0));
        directed.push_back(mk(16'h0400, 16'h8001, '1, '1, 0, 0));

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) send_block(directed[i]);
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 20) idle_on = 1'b0;
            if (i == 160) idle_on = 1'b1;
            if (i == 200) hold_req = 1'b1;
            if (i == 300) begin
                blk_if.valid <= 1'b0;
                while (weights_q.size() != 0) @(negedge i_clk);
            end
            v = mk(rand_half(), rand_half(), {$urandom, $urandom}, {$urandom, $urandom}, 0, 0);
            send_block(v);
        end
        blk_if.valid <= 1'b0;
        waited = 0;
        while (weights_q.size() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0 && weights_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
